[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the server selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form with an explicit clock and active-low reset.
`define ASSERT_GEN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form for modules whose ports are named clk_i and rst_ni.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_GEN(label, clk_i, rst_ni, prop, msg)

`endif

[sv/llss_pkg.sv]
// Types and codes shared by the least-loaded server selector.
`timescale 1ns / 1ps

package llss_pkg;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_INC      = 3'd1;
  localparam logic [2:0] OP_DEC      = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_REQUEST  = 3'd4;

  localparam logic [1:0] ST_ACK    = 2'd0;
  localparam logic [1:0] ST_CHOSEN = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Width used to extend slot indexes before comparing or truncating them.
  localparam int unsigned IdxExtW = 9;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot;
    logic [31:0] max_users;
    logic [31:0] initial_users;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_slot;
    logic [31:0] total_users;
  } res_t;

  typedef struct packed {
    logic [31:0] users;
    logic [31:0] limit;
  } entry_t;

  // Control from the sequencer to the slot table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_vld;
    logic clr_vld;
  } tbl_ctl_t;

endpackage

[sv/llss_table.sv]
// Slot table: user count and limit memory plus per-slot valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llss_table #(
  parameter int unsigned SERVER_SLOTS = 16,
  localparam int unsigned SlotW = $clog2(SERVER_SLOTS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  llss_pkg::tbl_ctl_t       ctl_i,
  input  logic [SlotW-1:0]         rd_addr_i,
  output llss_pkg::entry_t         rd_data_o,
  input  logic [SlotW-1:0]         wr_addr_i,
  input  llss_pkg::entry_t         wr_data_i,
  output logic [SERVER_SLOTS-1:0]  valid_o
);

  llss_pkg::entry_t        mem_q [SERVER_SLOTS];
  llss_pkg::entry_t        rd_data_q;
  logic [SERVER_SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // The memory itself is never cleared; an entry only counts once its flag is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctl_i.set_vld) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.clr_vld) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

  `ASSERT_DEF(a_set_clr_excl, !(ctl_i.set_vld && ctl_i.clr_vld), "set and clear of a valid flag in one cycle")
  `ASSERT_DEF(a_set_takes, ctl_i.set_vld |=> valid_q[$past(wr_addr_i)], "registered slot is not valid")
  `ASSERT_DEF(a_clr_takes, ctl_i.clr_vld |=> !valid_q[$past(wr_addr_i)], "removed slot is still valid")

endmodule

[sv/llss_ctrl.sv]
// Sequencer: read-modify-write of slot entries, selection scan and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llss_ctrl #(
  parameter int unsigned SERVER_SLOTS = 16,
  localparam int unsigned SlotW = $clog2(SERVER_SLOTS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  llss_pkg::item_t          in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output llss_pkg::res_t           out_data_o,
  output llss_pkg::tbl_ctl_t       tbl_ctl_o,
  output logic [SlotW-1:0]         rd_addr_o,
  output logic [SlotW-1:0]         wr_addr_o,
  output llss_pkg::entry_t         wr_data_o,
  input  llss_pkg::entry_t         rd_data_i,
  input  logic [SERVER_SLOTS-1:0]  valid_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  localparam logic [SlotW-1:0] LastIdx = SlotW'(SERVER_SLOTS - 1);

  state_e                          state_q, state_d;
  llss_pkg::item_t                 item_q, item_d;
  logic [SlotW-1:0]                addr_q, addr_d;
  logic                            inrange_q, inrange_d;
  logic [SlotW-1:0]                idx_q, idx_d;
  logic                            any_q, any_d;
  logic                            found_q, found_d;
  logic [31:0]                     best_q, best_d;
  logic [SlotW-1:0]                pick_q, pick_d;
  logic [31:0]                     total_q, total_d;
  llss_pkg::res_t                  res_q, res_d;
  logic                            out_valid_q, out_valid_d;
  llss_pkg::res_t                  out_data_q, out_data_d;

  logic [llss_pkg::IdxExtW-1:0]    slot_ext;
  logic [llss_pkg::IdxExtW-1:0]    pick_ext;
  logic                            in_range;
  logic                            slot_ok;
  logic                            scan_vld;
  logic                            out_free;

  assign slot_ext = llss_pkg::IdxExtW'(in_data_i.slot);
  assign in_range = slot_ext < llss_pkg::IdxExtW'(SERVER_SLOTS);
  assign slot_ok  = inrange_q && valid_i[addr_q];
  assign scan_vld = valid_i[idx_q];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    addr_d      = addr_q;
    inrange_d   = inrange_q;
    idx_d       = idx_q;
    any_d       = any_q;
    found_d     = found_q;
    best_d      = best_q;
    pick_d      = pick_q;
    total_d     = total_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    pick_ext    = '0;
    tbl_ctl_o   = '0;
    rd_addr_o   = slot_ext[SlotW-1:0];
    wr_addr_o   = addr_q;
    wr_data_o   = '{users: item_q.initial_users, limit: item_q.max_users};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d          = in_data_i;
          addr_d          = slot_ext[SlotW-1:0];
          inrange_d       = in_range;
          tbl_ctl_o.rd_en = 1'b1;
          if (in_data_i.opcode == llss_pkg::OP_REQUEST) begin
            rd_addr_o = '0;
            idx_d     = '0;
            any_d     = 1'b0;
            found_d   = 1'b0;
            best_d    = '1;
            pick_d    = '0;
            state_d   = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        case (item_q.opcode)
          llss_pkg::OP_REGISTER: begin
            if (inrange_q && !valid_i[addr_q]) begin
              tbl_ctl_o.wr_en   = 1'b1;
              tbl_ctl_o.set_vld = 1'b1;
            end
            total_d = total_q + item_q.initial_users;
          end
          llss_pkg::OP_INC: begin
            if (slot_ok) begin
              tbl_ctl_o.wr_en = 1'b1;
              wr_data_o       = '{users: rd_data_i.users + 32'd1, limit: rd_data_i.limit};
              total_d         = total_q + 32'd1;
            end
          end
          llss_pkg::OP_DEC: begin
            if (slot_ok) begin
              tbl_ctl_o.wr_en = 1'b1;
              wr_data_o       = '{users: rd_data_i.users - 32'd1, limit: rd_data_i.limit};
              total_d         = total_q - 32'd1;
            end
          end
          llss_pkg::OP_REMOVE: begin
            if (slot_ok) begin
              tbl_ctl_o.clr_vld = 1'b1;
              total_d           = total_q - rd_data_i.users;
            end
          end
          default: begin
          end
        endcase
        res_d   = '{status: llss_pkg::ST_ACK, chosen_slot: 4'd0, total_users: total_d};
        state_d = S_DONE;
      end
      S_SCAN: begin
        // rd_data_i holds the entry at idx_q, read in the previous cycle.
        if (scan_vld) begin
          any_d = 1'b1;
          if ((rd_data_i.users < rd_data_i.limit) && (rd_data_i.users < best_q)) begin
            best_d  = rd_data_i.users;
            pick_d  = idx_q;
            found_d = 1'b1;
          end
        end
        if (idx_q == LastIdx) begin
          pick_ext = llss_pkg::IdxExtW'(pick_d);
          if (!any_d) begin
            res_d = '{status: llss_pkg::ST_NONE, chosen_slot: 4'd0, total_users: total_q};
          end else if (!found_d) begin
            res_d = '{status: llss_pkg::ST_FULL, chosen_slot: 4'd0, total_users: total_q};
          end else begin
            res_d = '{status: llss_pkg::ST_CHOSEN, chosen_slot: pick_ext[3:0],
                      total_users: total_q};
          end
          state_d = S_DONE;
        end else begin
          tbl_ctl_o.rd_en = 1'b1;
          rd_addr_o       = idx_q + 1'b1;
          idx_d           = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      addr_q      <= '0;
      inrange_q   <= 1'b0;
      idx_q       <= '0;
      any_q       <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      pick_q      <= '0;
      total_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      addr_q      <= addr_d;
      inrange_q   <= inrange_d;
      idx_q       <= idx_d;
      any_q       <= any_d;
      found_q     <= found_d;
      best_q      <= best_d;
      pick_q      <= pick_d;
      total_q     <= total_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_DEF(a_accept_starts, (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE), "accepted transaction did not start")
  `ASSERT_DEF(a_done_delivers, (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE), "finished result not loaded")
  `ASSERT_DEF(a_scan_no_write, (state_q == S_SCAN) |-> !tbl_ctl_o.wr_en && !tbl_ctl_o.clr_vld, "table changed during a selection scan")

endmodule

[sv/least_loaded_server_select.sv]
// Top level of the least-loaded server selector.
`timescale 1ns / 1ps

// Least-loaded server selector. Each transaction carries one operation
// (register, user increment, user decrement, remove, request) and yields
// exactly one result with a status, the chosen slot and the running user
// total. Slot counts and limits live in a single-port-read synchronous
// memory; valid flags are flip-flops cleared at reset, so the block is
// ready right after reset with no clearing pass. One transaction is worked
// on at a time. Register, increment, decrement, remove and unknown opcodes
// pass through the acceptance cycle with the memory read, the update and
// write back, and the result load into the output register. A request
// instead runs a scan that reads one slot per cycle through the memory
// read port, from slot 0 to the last, before its result load. While the
// output register holds a stalled result, the block waits before its
// result load. A finished result waits in the output register while the
// next transaction is accepted.
module least_loaded_server_select #(
  parameter int unsigned SERVER_SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  llss_pkg::item_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output llss_pkg::res_t  out_data_o
);

  localparam int unsigned SlotW = $clog2(SERVER_SLOTS);

  llss_pkg::tbl_ctl_t      tbl_ctl;
  logic [SlotW-1:0]        rd_addr;
  logic [SlotW-1:0]        wr_addr;
  llss_pkg::entry_t        wr_data;
  llss_pkg::entry_t        rd_data;
  logic [SERVER_SLOTS-1:0] slot_valid;

  llss_ctrl #(
    .SERVER_SLOTS(SERVER_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .tbl_ctl_o   (tbl_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_data_i   (rd_data),
    .valid_i     (slot_valid)
  );

  llss_table #(
    .SERVER_SLOTS(SERVER_SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tbl_ctl),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .valid_o   (slot_valid)
  );

endmodule
